// File: src/hsl_pkg.sv
// Shared types and constants for the HSL to RGB converter.
package hsl_pkg;

    localparam int HSL_W   = 16;    // input field width
    localparam int CHAN_W  = 8;     // output channel width
    localparam int STAGES  = 7;     // register stages in the pipeline
    localparam int CH_N    = 3;     // channel values per item: c + m, x + m, m

    localparam int CH_C    = 0;
    localparam int CH_X    = 1;
    localparam int CH_0    = 2;

    localparam int A_W     = 17;            // 1 - |2l - 1|, scaled
    localparam int T_W     = A_W + HSL_W;   // chroma product a * s

    localparam int DEG_TURN   = 360;
    localparam int DEG_SECTOR = 60;
    localparam int PCT_FULL   = 100;
    localparam int SECTORS    = 6;
    localparam int HDEG_W     = 9;          // reduced hue in degrees

    // hue / 360 as (hue * HUE_RECIP) >> HUE_RECIP_SHIFT, exact for 16-bit hue
    localparam int HUE_RECIP       = 93207;
    localparam int HUE_RECIP_W     = 17;
    localparam int HUE_RECIP_SHIFT = 25;
    localparam int Q360_W          = 8;

    // integer form: channel = floor((17 * N + 40000) / 80000)
    localparam int INT_LIGHT_K = 12000;     // 2 * 100 * 60
    localparam int INT_KL_W    = 30;
    localparam int INT_N_W     = 21;
    localparam int INT_SCALE   = 17;
    localparam int INT_ROUND   = 40000;
    localparam int INT_X_W     = 25;
    localparam int INT_PRE_SHIFT = 7;       // 80000 = 128 * 625
    localparam int INT_Y_W     = 18;

    // y / 625 as (y * SCALE_RECIP) >> SCALE_RECIP_SHIFT, exact for 18-bit y
    localparam int SCALE_RECIP       = 429497;
    localparam int SCALE_RECIP_SHIFT = 28;
    localparam int INT_P_W           = INT_Y_W + 19;
    localparam int INT_Q_W           = INT_P_W - SCALE_RECIP_SHIFT;

    localparam int FRAC_SCALE = 510;
    localparam int CHAN_MAX   = 255;

    typedef enum logic {
        KIND_INT  = 1'b0,
        KIND_FRAC = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

// File: src/hsl_if.sv
// Stream interfaces for HSL input items and RGB result items.
interface hsl_in_if import hsl_pkg::*; ();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [HSL_W-1:0]  hue;
    logic [HSL_W-1:0]  saturation;
    logic [HSL_W-1:0]  lightness;

    modport source (output valid, output kind, output hue, output saturation,
                    output lightness, input ready);
    modport sink   (input valid, input kind, input hue, input saturation,
                    input lightness, output ready);
endinterface

interface hsl_out_if import hsl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hsl_pipe_ctrl.sv
// Valid bits and per-stage load enables of the conversion pipeline.
module hsl_pipe_ctrl import hsl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hsl_valid,
    output logic       hsl_ready,
    output logic       rgb_valid,
    input  logic       rgb_ready,
    output pipe_ctrl_t ctrl
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   ready;

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        ready[STAGES] = rgb_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? hsl_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = ready[STAGES-1:0];
    assign hsl_ready = ready[0];
    assign rgb_valid = valid_reg[STAGES-1];

endmodule

// File: src/hsl_front.sv
// Front stages: hue reduction, clamping, chroma product and sector decode.
module hsl_front import hsl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  pipe_ctrl_t           ctrl,
    input  kind_t                kind,
    input  logic [HSL_W-1:0]     hue,
    input  logic [HSL_W-1:0]     saturation,
    input  logic [HSL_W-1:0]     lightness,
    output kind_t                s3_kind,
    output sector_t              s3_sector,
    output logic [FRAC_BITS:0]   s3_g,
    output logic [T_W-1:0]       s3_t,
    output logic [HSL_W-1:0]     s3_lit
);

    localparam int HMW = (FRAC_BITS < HSL_W) ? FRAC_BITS : HSL_W;
    localparam int PW  = FRAC_BITS + 3;
    localparam int GW  = FRAC_BITS + 1;
    localparam int CW  = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
    localparam int HPW = HSL_W + HUE_RECIP_W;
    localparam logic [CW-1:0]    FRAC_ONE_C = CW'(1) << FRAC_BITS;
    localparam logic [HSL_W-1:0] HUE_MASK   = HSL_W'((CW'(1) << HMW) - CW'(1));

    // stage 1
    logic [HPW-1:0]      hue_prod;
    logic [CW-1:0]       lim;
    logic [CW-1:0]       sat_x;
    logic [CW-1:0]       lit_x;
    logic [CW-1:0]       sat_c;
    logic [CW-1:0]       lit_c;
    logic signed [CW-1:0] diff;
    logic [CW-1:0]       mag;
    logic [CW-1:0]       a_full;
    logic [HSL_W-1:0]    hue_next;

    kind_t               s1_kind_reg;
    logic [HSL_W-1:0]    s1_hue_reg;
    logic [Q360_W-1:0]   s1_q_reg;
    logic [HSL_W-1:0]    s1_sat_reg;
    logic [HSL_W-1:0]    s1_lit_reg;
    logic [A_W-1:0]      s1_a_reg;

    always_comb
    begin
        hue_prod = HPW'(hue) * HPW'(HUE_RECIP);
        hue_next = (kind == KIND_FRAC) ? (hue & HUE_MASK) : hue;
        lim      = (kind == KIND_FRAC) ? FRAC_ONE_C : CW'(PCT_FULL);
        sat_x    = CW'(saturation);
        lit_x    = CW'(lightness);
        sat_c    = (sat_x > lim) ? lim : sat_x;
        lit_c    = (lit_x > lim) ? lim : lit_x;
        diff     = signed'(lit_c << 1) - signed'(lim);
        mag      = diff[CW-1] ? unsigned'(-diff) : unsigned'(diff);
        a_full   = lim - mag;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_kind_reg <= kind;
            s1_hue_reg  <= hue_next;
            s1_q_reg    <= hue_prod[HUE_RECIP_SHIFT +: Q360_W];
            s1_sat_reg  <= sat_c[HSL_W-1:0];
            s1_lit_reg  <= lit_c[HSL_W-1:0];
            s1_a_reg    <= a_full[A_W-1:0];
        end
    end

    // stage 2
    logic [HSL_W-1:0]    h_full;
    logic [PW-1:0]       pos_next;
    logic [T_W-1:0]      t_next;

    kind_t               s2_kind_reg;
    logic [PW-1:0]       s2_pos_reg;
    logic [T_W-1:0]      s2_t_reg;
    logic [HSL_W-1:0]    s2_lit_reg;

    always_comb
    begin
        h_full   = s1_hue_reg - (HSL_W'(s1_q_reg) * HSL_W'(DEG_TURN));
        pos_next = (s1_kind_reg == KIND_FRAC) ?
                   PW'(s1_hue_reg[HMW-1:0]) * PW'(SECTORS) :
                   PW'(h_full[HDEG_W-1:0]);
        t_next   = T_W'(s1_a_reg) * T_W'(s1_sat_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_pos_reg  <= pos_next;
            s2_t_reg    <= t_next;
            s2_lit_reg  <= s1_lit_reg;
        end
    end

    // stage 3
    logic [HDEG_W-1:0]   h;
    logic [HDEG_W-1:0]   h_base;
    sector_t             sec;
    logic [GW-1:0]       fnum;
    logic [GW-1:0]       dh;
    logic [GW-1:0]       g_next;

    kind_t               s3_kind_reg;
    sector_t             s3_sector_reg;
    logic [GW-1:0]       s3_g_reg;
    logic [T_W-1:0]      s3_t_reg;
    logic [HSL_W-1:0]    s3_lit_reg;

    always_comb
    begin
        h      = s2_pos_reg[HDEG_W-1:0];
        h_base = '0;
        sec    = SEC_R_Y;
        if (s2_kind_reg == KIND_FRAC)
        begin
            sec  = sector_t'(s2_pos_reg[PW-1:FRAC_BITS]);
            fnum = GW'(s2_pos_reg[FRAC_BITS-1:0]);
            dh   = GW'(1) << FRAC_BITS;
        end
        else
        begin
            priority if (h >= HDEG_W'(5 * DEG_SECTOR))
            begin
                sec    = SEC_M_R;
                h_base = HDEG_W'(5 * DEG_SECTOR);
            end
            else if (h >= HDEG_W'(4 * DEG_SECTOR))
            begin
                sec    = SEC_B_M;
                h_base = HDEG_W'(4 * DEG_SECTOR);
            end
            else if (h >= HDEG_W'(3 * DEG_SECTOR))
            begin
                sec    = SEC_C_B;
                h_base = HDEG_W'(3 * DEG_SECTOR);
            end
            else if (h >= HDEG_W'(2 * DEG_SECTOR))
            begin
                sec    = SEC_G_C;
                h_base = HDEG_W'(2 * DEG_SECTOR);
            end
            else if (h >= HDEG_W'(DEG_SECTOR))
            begin
                sec    = SEC_Y_G;
                h_base = HDEG_W'(DEG_SECTOR);
            end
            else
            begin
                sec    = SEC_R_Y;
                h_base = '0;
            end
            fnum = GW'(h - h_base);
            dh   = GW'(DEG_SECTOR);
        end
        // odd sectors run the secondary component downhill
        if (sec == SEC_Y_G || sec == SEC_C_B || sec == SEC_M_R)
        begin
            g_next = dh - fnum;
        end
        else
        begin
            g_next = fnum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            s3_kind_reg   <= s2_kind_reg;
            s3_sector_reg <= sec;
            s3_g_reg      <= g_next;
            s3_t_reg      <= s2_t_reg;
            s3_lit_reg    <= s2_lit_reg;
        end
    end

    assign s3_kind   = s3_kind_reg;
    assign s3_sector = s3_sector_reg;
    assign s3_g      = s3_g_reg;
    assign s3_t      = s3_t_reg;
    assign s3_lit    = s3_lit_reg;

endmodule

// File: src/hsl_mix.sv
// Middle stages: secondary product and the three channel numerators.
module hsl_mix import hsl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  pipe_ctrl_t                  ctrl,
    input  kind_t                       s3_kind,
    input  sector_t                     s3_sector,
    input  logic [FRAC_BITS:0]          s3_g,
    input  logic [T_W-1:0]              s3_t,
    input  logic [HSL_W-1:0]            s3_lit,
    output kind_t                       s5_kind,
    output sector_t                     s5_sector,
    output logic signed [3*FRAC_BITS+3:0] s5_n [CH_N]
);

    localparam int NW  = 3 * FRAC_BITS + 4;
    localparam int PRW = T_W + FRAC_BITS + 1;

    // stage 4: t * g
    logic [PRW-1:0]      prod;

    kind_t               s4_kind_reg;
    sector_t             s4_sector_reg;
    logic [T_W-1:0]      s4_t_reg;
    logic [PRW-1:0]      s4_p_reg;
    logic [HSL_W-1:0]    s4_lit_reg;

    assign prod = PRW'(s3_t) * PRW'(s3_g);

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            s4_kind_reg   <= s3_kind;
            s4_sector_reg <= s3_sector;
            s4_t_reg      <= s3_t;
            s4_p_reg      <= prod;
            s4_lit_reg    <= s3_lit;
        end
    end

    // stage 5: N = t * u + K * l for u = dh, 2g - dh, -dh
    logic signed [NW-1:0] t_w;
    logic signed [NW-1:0] p_w;
    logic signed [NW-1:0] tdh;
    logic signed [NW-1:0] kl;
    logic [INT_KL_W-1:0]  kl_int;

    kind_t               s5_kind_reg;
    sector_t             s5_sector_reg;
    logic signed [NW-1:0] s5_n_reg [CH_N];

    always_comb
    begin
        t_w    = signed'(NW'(s4_t_reg));
        p_w    = signed'(NW'(s4_p_reg));
        kl_int = INT_KL_W'(s4_lit_reg) * INT_KL_W'(INT_LIGHT_K);
        if (s4_kind_reg == KIND_FRAC)
        begin
            tdh = t_w <<< FRAC_BITS;
            kl  = signed'(NW'(s4_lit_reg)) <<< (2 * FRAC_BITS + 1);
        end
        else
        begin
            tdh = t_w * signed'(NW'(DEG_SECTOR));
            kl  = signed'(NW'(kl_int));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            s5_kind_reg    <= s4_kind_reg;
            s5_sector_reg  <= s4_sector_reg;
            s5_n_reg[CH_C] <= kl + tdh;
            s5_n_reg[CH_X] <= kl + (p_w <<< 1) - tdh;
            s5_n_reg[CH_0] <= kl - tdh;
        end
    end

    assign s5_kind   = s5_kind_reg;
    assign s5_sector = s5_sector_reg;
    assign s5_n      = s5_n_reg;

endmodule

// File: src/hsl_scale.sv
// Back stages: scale to 0..255 with round to nearest, route channels by sector.
module hsl_scale import hsl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  pipe_ctrl_t                    ctrl,
    input  kind_t                         s5_kind,
    input  sector_t                       s5_sector,
    input  logic signed [3*FRAC_BITS+3:0] s5_n [CH_N],
    output logic [CHAN_W-1:0]             red,
    output logic [CHAN_W-1:0]             green,
    output logic [CHAN_W-1:0]             blue
);

    localparam int NW  = 3 * FRAC_BITS + 4;
    localparam int WW  = NW + 9;
    localparam int FSH = 3 * FRAC_BITS + 2;
    localparam int QW  = WW - FSH;
    localparam logic [WW-1:0] FRAC_ROUND = WW'(1) << (3 * FRAC_BITS + 1);

    // stage 6: sign, integer pre-scale, fraction result
    logic [INT_X_W-1:0]  x;
    logic [WW-1:0]       w;
    logic [QW-1:0]       qw;
    logic                neg_next [CH_N];
    logic [INT_Y_W-1:0]  y_next   [CH_N];
    logic [CHAN_W-1:0]   qf_next  [CH_N];

    kind_t               s6_kind_reg;
    sector_t             s6_sector_reg;
    logic                s6_neg_reg [CH_N];
    logic [INT_Y_W-1:0]  s6_y_reg   [CH_N];
    logic [CHAN_W-1:0]   s6_qf_reg  [CH_N];

    always_comb
    begin
        x  = '0;
        w  = '0;
        qw = '0;
        for (int i = 0; i < CH_N; i++)
        begin
            neg_next[i] = s5_n[i][NW-1];
            x  = INT_X_W'(s5_n[i][INT_N_W-1:0]) * INT_X_W'(INT_SCALE)
                 + INT_X_W'(INT_ROUND);
            y_next[i] = x[INT_PRE_SHIFT +: INT_Y_W];
            w  = WW'(unsigned'(s5_n[i])) * WW'(FRAC_SCALE) + FRAC_ROUND;
            qw = w[FSH +: QW];
            qf_next[i] = (qw > QW'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : qw[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            s6_kind_reg   <= s5_kind;
            s6_sector_reg <= s5_sector;
            s6_neg_reg    <= neg_next;
            s6_y_reg      <= y_next;
            s6_qf_reg     <= qf_next;
        end
    end

    // stage 7: divide by 625 via reciprocal, clamp, route
    logic [INT_P_W-1:0]  prod;
    logic [INT_Q_W-1:0]  qi;
    logic [CHAN_W-1:0]   v [CH_N];
    logic [CHAN_W-1:0]   red_next;
    logic [CHAN_W-1:0]   green_next;
    logic [CHAN_W-1:0]   blue_next;

    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   blue_reg;

    always_comb
    begin
        prod = '0;
        qi   = '0;
        for (int i = 0; i < CH_N; i++)
        begin
            prod = INT_P_W'(s6_y_reg[i]) * INT_P_W'(SCALE_RECIP);
            qi   = prod[SCALE_RECIP_SHIFT +: INT_Q_W];
            if (s6_neg_reg[i])
            begin
                v[i] = '0;
            end
            else if (s6_kind_reg == KIND_FRAC)
            begin
                v[i] = s6_qf_reg[i];
            end
            else
            begin
                v[i] = (qi > INT_Q_W'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : qi[CHAN_W-1:0];
            end
        end

        unique case (s6_sector_reg)
            SEC_R_Y:
            begin
                red_next = v[CH_C]; green_next = v[CH_X]; blue_next = v[CH_0];
            end
            SEC_Y_G:
            begin
                red_next = v[CH_X]; green_next = v[CH_C]; blue_next = v[CH_0];
            end
            SEC_G_C:
            begin
                red_next = v[CH_0]; green_next = v[CH_C]; blue_next = v[CH_X];
            end
            SEC_C_B:
            begin
                red_next = v[CH_0]; green_next = v[CH_X]; blue_next = v[CH_C];
            end
            SEC_B_M:
            begin
                red_next = v[CH_X]; green_next = v[CH_0]; blue_next = v[CH_C];
            end
            default:
            begin
                red_next = v[CH_C]; green_next = v[CH_0]; blue_next = v[CH_X];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: src/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter.
//
//   port   role    payload                              transfer when
//   hsl    sink    kind, hue, saturation, lightness     hsl.valid && hsl.ready
//   rgb    source  red, green, blue                     rgb.valid && rgb.ready
//
// One item per clock sustained while rgb.ready is high; 7 register stages
// (hue reduction, chroma product, sector decode, secondary product, numerators,
// scaling, reciprocal divide and routing).
// Reset clears only the stage valid bits; data registers are not reset.
// Each stage loads when empty or when its content moves on, so bubbles are
// absorbed and input is taken while a result waits at the output register.
module hsl_to_rgb_converter import hsl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    hsl_in_if.sink   hsl,
    hsl_out_if.source rgb
);

    pipe_ctrl_t                    ctrl;
    kind_t                         s3_kind;
    sector_t                       s3_sector;
    logic [FRAC_BITS:0]            s3_g;
    logic [T_W-1:0]                s3_t;
    logic [HSL_W-1:0]              s3_lit;
    kind_t                         s5_kind;
    sector_t                       s5_sector;
    logic signed [3*FRAC_BITS+3:0] s5_n [CH_N];
    logic                          hsl_ready;
    logic                          rgb_valid;
    logic [CHAN_W-1:0]             red;
    logic [CHAN_W-1:0]             green;
    logic [CHAN_W-1:0]             blue;

    hsl_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsl_valid (hsl.valid),
        .hsl_ready (hsl_ready),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb.ready),
        .ctrl      (ctrl)
    );

    hsl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk        (clk),
        .ctrl       (ctrl),
        .kind       (hsl.kind),
        .hue        (hsl.hue),
        .saturation (hsl.saturation),
        .lightness  (hsl.lightness),
        .s3_kind    (s3_kind),
        .s3_sector  (s3_sector),
        .s3_g       (s3_g),
        .s3_t       (s3_t),
        .s3_lit     (s3_lit)
    );

    hsl_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk       (clk),
        .ctrl      (ctrl),
        .s3_kind   (s3_kind),
        .s3_sector (s3_sector),
        .s3_g      (s3_g),
        .s3_t      (s3_t),
        .s3_lit    (s3_lit),
        .s5_kind   (s5_kind),
        .s5_sector (s5_sector),
        .s5_n      (s5_n)
    );

    hsl_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .clk       (clk),
        .ctrl      (ctrl),
        .s5_kind   (s5_kind),
        .s5_sector (s5_sector),
        .s5_n      (s5_n),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign hsl.ready = hsl_ready;
    assign rgb.valid = rgb_valid;
    assign rgb.red   = red;
    assign rgb.green = green;
    assign rgb.blue  = blue;

endmodule
